/* src/bet_string_parser_assert.svh */
// Assertion macros shared by the bet string parser modules.
`ifndef BET_STRING_PARSER_ASSERT_SVH
`define BET_STRING_PARSER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define BSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define BSP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/bsp_pkg.sv */
// Shared types, character classes and constants of the bet string parser.
`default_nettype none

package bsp_pkg;

   // Field widths
   localparam int CHAR_W      = 8;
   localparam int BET_W       = 31;
   localparam int VALUE_W     = 32;
   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CLS_W       = 4;
   localparam int DIGIT_W     = 4;
   localparam int POW_W       = 17;

   // Parameter defaults
   localparam int MAX_CHARS_DEF  = 256;
   localparam int FIFO_DEPTH_DEF = 4;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_RAISE_PERCENT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR        = 1'd1;
   localparam logic [CFG_W-1:0]       RAISE_PERCENT_RST = 10'd25;
   localparam logic [CFG_W-1:0]       FACTOR_RST        = 10'd2;

   // Character classes
   localparam logic [CLS_W-1:0] CLS_END   = 4'd0;
   localparam logic [CLS_W-1:0] CLS_DIGIT = 4'd1;
   localparam logic [CLS_W-1:0] CLS_K     = 4'd2;
   localparam logic [CLS_W-1:0] CLS_M     = 4'd3;
   localparam logic [CLS_W-1:0] CLS_PLUS  = 4'd4;
   localparam logic [CLS_W-1:0] CLS_MINUS = 4'd5;
   localparam logic [CLS_W-1:0] CLS_MUL   = 4'd6;
   localparam logic [CLS_W-1:0] CLS_SPACE = 4'd7;
   localparam logic [CLS_W-1:0] CLS_OTHER = 4'd8;

   // Arithmetic constants
   localparam logic [VALUE_W-1:0] TEN      = 32'd10;
   localparam logic [VALUE_W-1:0] HUNDRED  = 32'd100;
   localparam logic [VALUE_W-1:0] THOUSAND = 32'd1000;
   localparam logic [VALUE_W-1:0] MILLION  = 32'd1000000;
   // ceil(2^37 / 100): exact reciprocal of 100 for 32-bit magnitudes
   localparam logic [VALUE_W-1:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int                 DIV100_SHIFT = 37;

   // One classified character between front and back
   typedef struct packed {
      logic [CLS_W-1:0]   cls;
      logic [DIGIT_W-1:0] digit;
      logic [BET_W-1:0]   bet;
   } word_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Place value of the next fractional digit
   function automatic logic [POW_W-1:0] pow10(input logic [2:0] exp);
      logic [POW_W-1:0] pow;
      unique case (exp)
         3'd0:    pow = 17'd1;
         3'd1:    pow = 17'd10;
         3'd2:    pow = 17'd100;
         3'd3:    pow = 17'd1000;
         3'd4:    pow = 17'd10000;
         3'd5:    pow = 17'd100000;
         default: pow = 17'd1;
      endcase
      return pow;
   endfunction

endpackage

`default_nettype wire

/* src/bsp_front.sv */
// Front end: accepts characters, drops those past the length limit, classifies the rest.
`default_nettype none
`include "bet_string_parser_assert.svh"

module bsp_front #(
   parameter int MAX_CHARS = bsp_pkg::MAX_CHARS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [bsp_pkg::CHAR_W-1:0]   req_character,
   input  wire logic [bsp_pkg::BET_W-1:0]    req_current_bet,
   input  wire bsp_pkg::fifo_status_type     fifo_status,
   output logic                              push,
   output bsp_pkg::word_type                 push_word
);

   localparam int                CNT_W    = (MAX_CHARS > 2) ? $clog2(MAX_CHARS) : 1;
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_CHARS - 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             accept;
   logic             is_end;
   logic             in_room;
   logic [bsp_pkg::CLS_W-1:0] cls;

   // Hold the sender while the queue is full
   assign req_stall = fifo_status.full;
   assign accept    = req_valid && !fifo_status.full;
   assign is_end    = (req_character == 8'd0);
   assign in_room   = (cnt_ff < CNT_LAST);

   // Classify the character
   always_comb begin
      cls = bsp_pkg::CLS_OTHER;
      if (is_end) begin
         cls = bsp_pkg::CLS_END;
      end else if (req_character >= 8'd48 && req_character <= 8'd57) begin
         cls = bsp_pkg::CLS_DIGIT;
      end else if (req_character == 8'd107 || req_character == 8'd75) begin
         cls = bsp_pkg::CLS_K;
      end else if (req_character == 8'd109 || req_character == 8'd77) begin
         cls = bsp_pkg::CLS_M;
      end else if (req_character == 8'd43) begin
         cls = bsp_pkg::CLS_PLUS;
      end else if (req_character == 8'd45) begin
         cls = bsp_pkg::CLS_MINUS;
      end else if (req_character == 8'd42 || req_character == 8'd120) begin
         cls = bsp_pkg::CLS_MUL;
      end else if (req_character == 8'd32
                   || (req_character >= 8'd9 && req_character <= 8'd13)) begin
         cls = bsp_pkg::CLS_SPACE;
      end
   end

   // Push the terminator always, other characters only inside the limit
   assign push            = accept && (is_end || in_room);
   assign push_word.cls   = cls;
   assign push_word.digit = req_character[bsp_pkg::DIGIT_W-1:0];
   assign push_word.bet   = req_current_bet;

   // Count characters of the current string
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (is_end) begin
            cnt_in = '0;
         end else if (in_room) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `BSP_ASSERT_NEVER(a_count_in_range, clock, reset, cnt_ff > CNT_LAST, "char count past limit")
   `BSP_ASSERT(a_end_clears_count, clock, reset, (accept && is_end) |=> (cnt_ff == '0), "count not cleared")

endmodule

`default_nettype wire

/* src/bsp_fifo.sv */
// Short queue of classified words between front and back.
`default_nettype none
`include "bet_string_parser_assert.svh"

module bsp_fifo #(
   parameter int DEPTH = bsp_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bsp_pkg::word_type         push_word,
   input  wire logic                      pop,
   output bsp_pkg::word_type              pop_word,
   output bsp_pkg::fifo_status_type       status
);

   localparam int                PTR_W    = $clog2(DEPTH);
   localparam int                CNT_W    = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);

   bsp_pkg::word_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign pop_word     = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   `BSP_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && status.full && !pop, "push into full queue")
   `BSP_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && status.empty, "pop from empty queue")

endmodule

`default_nettype wire

/* src/bsp_back.sv */
// Back end: parse state machine and the pipeline that computes the bet on the terminator.
`default_nettype none
`include "bet_string_parser_assert.svh"

module bsp_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bsp_pkg::word_type               fifo_word,
   input  wire bsp_pkg::fifo_status_type        fifo_status,
   output logic                                 pop,
   input  wire logic [bsp_pkg::CFG_W-1:0]       raise_percent,
   input  wire logic [bsp_pkg::CFG_W-1:0]       factor,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [bsp_pkg::VALUE_W-1:0]   rsp_bet_value
);

   localparam logic [3:0] M_START    = 4'd0;
   localparam logic [3:0] M_INT      = 4'd1;
   localparam logic [3:0] M_FRAC     = 4'd2;
   localparam logic [3:0] M_SKIP     = 4'd3;
   localparam logic [3:0] M_BAD      = 4'd4;
   localparam logic [3:0] M_PLUS_WS  = 4'd5;
   localparam logic [3:0] M_PLUS_DIG = 4'd6;
   localparam logic [3:0] M_PLUS_END = 4'd7;
   localparam logic [3:0] M_MUL_WS   = 4'd8;
   localparam logic [3:0] M_MUL_DIG  = 4'd9;
   localparam logic [3:0] M_MUL_END  = 4'd10;

   localparam int W = bsp_pkg::VALUE_W;

   // Parse state
   logic [3:0]   mode_ff;
   logic [3:0]   mode_in;
   logic [W-1:0] acc_ff;
   logic [W-1:0] acc_in;
   logic [2:0]   left_ff;
   logic [2:0]   left_in;
   logic         minus_ff;
   logic         minus_in;
   logic         alone_ff;
   logic         alone_in;

   // Finish pipeline
   logic         fa_valid_ff;
   logic         fa_valid_in;
   logic [W-1:0] fa_a_ff;
   logic [W-1:0] fa_a_in;
   logic [W-1:0] fa_b_ff;
   logic [W-1:0] fa_b_in;
   logic         fa_plus_ff;
   logic         fa_plus_in;
   logic         fb_valid_ff;
   logic [W-1:0] fb_prod_ff;
   logic         fb_plus_ff;
   logic         fc_valid_ff;
   logic [W-1:0] fc_val_ff;
   logic [W-1:0] fc_val_in;
   logic         fc_neg_ff;
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_value_ff;

   logic         en;
   logic         is_digit;
   logic         mul_grp;
   logic [3:0]   dig_code;
   logic [3:0]   end_code;
   logic [W-1:0] digit_ext;
   logic [W-1:0] arg;
   logic [W-1:0] bet_ext;
   logic [20:0]  frac_prod;
   logic [W-1:0] mag;
   logic [2*W-1:0] quo_full;

   // Stall the whole back end while the output word waits
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign pop       = en && !fifo_status.empty;

   assign is_digit  = (fifo_word.cls == bsp_pkg::CLS_DIGIT);
   assign digit_ext = W'(fifo_word.digit);
   assign bet_ext   = W'(fifo_word.bet);
   assign arg       = minus_ff ? (W'(0) - acc_ff) : acc_ff;
   assign frac_prod = 21'(fifo_word.digit) * 21'(bsp_pkg::pow10(left_ff - 3'd1));
   assign mul_grp   = (mode_ff == M_MUL_WS) || (mode_ff == M_MUL_DIG)
                      || (mode_ff == M_MUL_END);
   assign dig_code  = mul_grp ? M_MUL_DIG : M_PLUS_DIG;
   assign end_code  = mul_grp ? M_MUL_END : M_PLUS_END;

   // Step the parser on each popped word
   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      left_in     = left_ff;
      minus_in    = minus_ff;
      alone_in    = alone_ff;
      fa_valid_in = 1'b0;
      fa_a_in     = '0;
      fa_b_in     = '0;
      fa_plus_in  = 1'b0;
      if (pop) begin
         if (fifo_word.cls == bsp_pkg::CLS_END) begin
            // Set up the final multiply and return to start of string
            fa_valid_in = 1'b1;
            unique case (mode_ff) inside
               M_INT, M_FRAC, M_SKIP: begin
                  fa_a_in = acc_ff;
                  fa_b_in = W'(1);
               end
               M_PLUS_WS, M_PLUS_DIG, M_PLUS_END: begin
                  fa_a_in    = bet_ext;
                  fa_b_in    = bsp_pkg::HUNDRED + (alone_ff ? W'(raise_percent) : arg);
                  fa_plus_in = 1'b1;
               end
               M_MUL_WS, M_MUL_DIG, M_MUL_END: begin
                  fa_a_in = bet_ext;
                  fa_b_in = alone_ff ? W'(factor) : arg;
               end
               default: begin
                  fa_a_in = '0;
                  fa_b_in = '0;
               end
            endcase
            mode_in  = M_START;
            acc_in   = '0;
            left_in  = '0;
            minus_in = 1'b0;
            alone_in = 1'b1;
         end else begin
            unique case (mode_ff) inside
               M_START: begin
                  if (is_digit) begin
                     acc_in  = digit_ext;
                     mode_in = M_INT;
                  end else if (fifo_word.cls == bsp_pkg::CLS_PLUS) begin
                     mode_in = M_PLUS_WS;
                  end else if (fifo_word.cls == bsp_pkg::CLS_MUL) begin
                     mode_in = M_MUL_WS;
                  end else begin
                     mode_in = M_BAD;
                  end
               end
               M_INT: begin
                  if (is_digit) begin
                     acc_in = W'(acc_ff * bsp_pkg::TEN) + digit_ext;
                  end else if (fifo_word.cls == bsp_pkg::CLS_K) begin
                     acc_in  = W'(acc_ff * bsp_pkg::THOUSAND);
                     left_in = 3'd3;
                     mode_in = M_FRAC;
                  end else if (fifo_word.cls == bsp_pkg::CLS_M) begin
                     acc_in  = W'(acc_ff * bsp_pkg::MILLION);
                     left_in = 3'd6;
                     mode_in = M_FRAC;
                  end else begin
                     mode_in = M_BAD;
                  end
               end
               M_FRAC: begin
                  if (is_digit) begin
                     if (left_ff != 3'd0) begin
                        left_in = left_ff - 3'd1;
                        acc_in  = acc_ff + W'(frac_prod);
                     end else begin
                        mode_in = M_SKIP;
                     end
                  end else begin
                     mode_in = M_BAD;
                  end
               end
               M_PLUS_WS, M_MUL_WS: begin
                  alone_in = 1'b0;
                  if (fifo_word.cls == bsp_pkg::CLS_SPACE) begin
                     mode_in = mode_ff;
                  end else if (fifo_word.cls == bsp_pkg::CLS_PLUS
                               || fifo_word.cls == bsp_pkg::CLS_MINUS) begin
                     minus_in = (fifo_word.cls == bsp_pkg::CLS_MINUS);
                     mode_in  = dig_code;
                  end else if (is_digit) begin
                     acc_in  = digit_ext;
                     mode_in = dig_code;
                  end else begin
                     mode_in = end_code;
                  end
               end
               M_PLUS_DIG, M_MUL_DIG: begin
                  alone_in = 1'b0;
                  if (is_digit) begin
                     acc_in = W'(acc_ff * bsp_pkg::TEN) + digit_ext;
                  end else begin
                     mode_in = end_code;
                  end
               end
               M_PLUS_END, M_MUL_END: begin
                  alone_in = 1'b0;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_START;
         acc_ff   <= '0;
         left_ff  <= '0;
         minus_ff <= 1'b0;
         alone_ff <= 1'b1;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         minus_ff <= minus_in;
         alone_ff <= alone_in;
      end
   end

   // Divide a raised bet by 100, truncating toward zero
   assign mag       = fb_prod_ff[W-1] ? (W'(0) - fb_prod_ff) : fb_prod_ff;
   assign quo_full  = mag * bsp_pkg::DIV100_MAGIC;
   assign fc_val_in = fb_plus_ff ? W'(quo_full[2*W-1:bsp_pkg::DIV100_SHIFT]) : fb_prod_ff;

   // Advance the finish pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         fa_valid_ff  <= 1'b0;
         fb_valid_ff  <= 1'b0;
         fc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         fa_valid_ff  <= fa_valid_in;
         fb_valid_ff  <= fa_valid_ff;
         fc_valid_ff  <= fb_valid_ff;
         rsp_valid_ff <= fc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fa_a_ff      <= fa_a_in;
         fa_b_ff      <= fa_b_in;
         fa_plus_ff   <= fa_plus_in;
         fb_prod_ff   <= W'(fa_a_ff * fa_b_ff);
         fb_plus_ff   <= fa_plus_ff;
         fc_val_ff    <= fc_val_in;
         fc_neg_ff    <= fb_plus_ff && fb_prod_ff[W-1];
         rsp_value_ff <= fc_neg_ff ? (W'(0) - fc_val_ff) : fc_val_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bet_value = rsp_value_ff;

   `BSP_ASSERT(a_end_resets_mode, clock, reset, (pop && fifo_word.cls == bsp_pkg::CLS_END) |=> (mode_ff == M_START), "parser not back at start")
   `BSP_ASSERT(a_result_reaches_output, clock, reset, (en && fc_valid_ff) |=> rsp_valid_ff, "result lost before output")

endmodule

`default_nettype wire

/* src/bet_string_parser.sv */
// Top level of the bet string parser: configuration registers, front end, queue and back end.
`default_nettype none

// Takes a bet string one character per word and returns one signed 32-bit bet on the zero
// byte that ends it: a decimal number with optional k/m suffix, a "+" raise by percent, or
// a "*"/"x" multiple of the current bet; malformed or empty strings give 0. One character
// is accepted every cycle unless the queue is full. The result passes the pop and parse step,
// the 32x32 product, the reciprocal divide by 100 and the sign fix into the output register.
// While rsp_stall holds a waiting result the whole back end holds, and a queue of FIFO_DEPTH
// words keeps taking characters until it fills. The user must write configuration registers
// through the csr_ port only while no string is in flight; the block does not enforce it.
module bet_string_parser #(
   parameter int MAX_CHARS  = bsp_pkg::MAX_CHARS_DEF,
   parameter int FIFO_DEPTH = bsp_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [bsp_pkg::CHAR_W-1:0]         req_character,
   input  wire logic [bsp_pkg::BET_W-1:0]          req_current_bet,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [bsp_pkg::VALUE_W-1:0]      rsp_bet_value,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bsp_pkg::CFG_W-1:0]          csr_wdata
);

   logic [bsp_pkg::CFG_W-1:0] raise_percent_ff;
   logic [bsp_pkg::CFG_W-1:0] factor_ff;
   logic                      push;
   logic                      pop;
   bsp_pkg::word_type         push_word;
   bsp_pkg::word_type         pop_word;
   bsp_pkg::fifo_status_type  fifo_status;

   // Take register writes every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raise_percent_ff <= bsp_pkg::RAISE_PERCENT_RST;
         factor_ff        <= bsp_pkg::FACTOR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsp_pkg::CSR_RAISE_PERCENT: raise_percent_ff <= csr_wdata;
            bsp_pkg::CSR_FACTOR:        factor_ff        <= csr_wdata;
            default:                    raise_percent_ff <= raise_percent_ff;
         endcase
      end
   end

   bsp_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_current_bet (req_current_bet),
      .fifo_status     (fifo_status),
      .push            (push),
      .push_word       (push_word)
   );

   bsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .status    (fifo_status)
   );

   bsp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_word     (pop_word),
      .fifo_status   (fifo_status),
      .pop           (pop),
      .raise_percent (raise_percent_ff),
      .factor        (factor_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bet_value (rsp_bet_value)
   );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the bet string parser: directed table, random strings, scoreboard.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAR_LIMIT   = bsp_pkg::MAX_CHARS_DEF - 1;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 120;
   localparam int N_DIRECTED   = 26;

   // Characters with a meaning to the parser
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_STAR  = "*";
   localparam logic [7:0] CH_X     = "x";
   localparam logic [7:0] CH_K     = "k";
   localparam logic [7:0] CH_UK    = "K";
   localparam logic [7:0] CH_M     = "m";
   localparam logic [7:0] CH_UM    = "M";
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";

   typedef enum logic [3:0] {
      PM_START, PM_INT, PM_FRAC, PM_SKIP, PM_BAD,
      PM_PLUS_WS, PM_PLUS_DIG, PM_PLUS_END,
      PM_MUL_WS, PM_MUL_DIG, PM_MUL_END
   } parse_mode_type;

   // One directed string: head, then fill_len copies of fill, then tail, then the zero byte
   typedef struct {
      string                     head;
      logic [7:0]                fill;
      int                        fill_len;
      string                     tail;
      logic [bsp_pkg::BET_W-1:0] bet;
      bit                        known;
      logic signed [31:0]        value;
   } bet_case_type;

   bet_case_type directed_cases [N_DIRECTED] = '{
      '{"",           CH_NUL,   0,   "",   31'd7,          1'b1, 32'sd0},
      '{"0",          CH_NUL,   0,   "",   31'd5,          1'b1, 32'sd0},
      '{"2147483647", CH_NUL,   0,   "",   31'd0,          1'b1, 32'sd2147483647},
      '{"4294967295", CH_NUL,   0,   "",   31'd0,          1'b1, -32'sd1},
      '{"12k",        CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd12000},
      '{"1K5",        CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd1500},
      '{"3m141592",   CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd3141592},
      '{"2M1234567",  CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd2123456},
      '{"1k9999z!",   CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd1999},
      '{"1k999z",     CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd0},
      '{"1k5x",       CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd0},
      '{"12a",        CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd0},
      '{"k",          CH_NUL,   0,   "",   31'd9,          1'b1, 32'sd0},
      '{"\377",       CH_NUL,   0,   "",   31'h7FFFFFFF,   1'b1, 32'sd0},
      '{"+",          CH_NUL,   0,   "",   31'd100,        1'b1, 32'sd125},
      '{"+50",        CH_NUL,   0,   "",   31'd200,        1'b1, 32'sd300},
      '{"+ \t-50",    CH_NUL,   0,   "",   31'd200,        1'b1, 32'sd100},
      '{"+abc",       CH_NUL,   0,   "",   31'd100,        1'b1, 32'sd100},
      '{"*",          CH_NUL,   0,   "",   31'd7,          1'b1, 32'sd14},
      '{"x3",         CH_NUL,   0,   "",   31'd1000,       1'b1, 32'sd3000},
      '{"*-1",        CH_NUL,   0,   "",   31'd5,          1'b1, -32'sd5},
      '{"x\012\013\014\015 \01112", CH_NUL, 0, "", 31'd2,  1'b1, 32'sd24},
      '{"+-200",      CH_NUL,   0,   "",   31'h7FFFFFFF,   1'b0, 32'sd0},
      '{"*",          CH_NUL,   0,   "",   31'h7FFFFFFF,   1'b0, 32'sd0},
      '{"+",          CH_SPACE, 254, "50", 31'd100,        1'b1, 32'sd100},
      '{"+",          CH_SPACE, 253, "50", 31'd100,        1'b1, 32'sd105}
   };

   logic                              clock;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic [bsp_pkg::CHAR_W-1:0]        req_character   = '0;
   logic [bsp_pkg::BET_W-1:0]         req_current_bet = '0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic signed [bsp_pkg::VALUE_W-1:0] rsp_bet_value;
   logic                              csr_valid       = 1'b0;
   logic                              csr_ready;
   logic [bsp_pkg::CSR_INDEX_W-1:0]   csr_index       = '0;
   logic [bsp_pkg::CFG_W-1:0]         csr_wdata       = '0;

   bet_string_parser u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_current_bet (req_current_bet),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bet_value   (rsp_bet_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Parser shadow state and register copies
   parse_mode_type            pm        = PM_START;
   logic [31:0]               acc       = '0;
   logic [19:0]               place     = '0;
   bit                        neg       = 1'b0;
   bit                        alone     = 1'b1;
   int                        nchars    = 0;
   logic [bsp_pkg::CFG_W-1:0] raise_pct = bsp_pkg::RAISE_PERCENT_RST;
   logic [bsp_pkg::CFG_W-1:0] factor    = bsp_pkg::FACTOR_RST;

   logic signed [31:0] bet_queue [$];
   logic [7:0]         bet_text [$];
   int                 errors    = 0;
   bit                 tx_burst  = 1'b0;
   bit                 rx_burst  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_space();
      int k;
      k = $urandom_range(8, 13);
      return (k == 8) ? CH_SPACE : 8'(k);
   endfunction

   function automatic logic [7:0] rand_junk();
      return 8'($urandom_range(1, 255));
   endfunction

   // Read the number after a plus or multiply symbol, atoi style
   task automatic scan_operand(input logic [7:0] c, input parse_mode_type ws,
                               input parse_mode_type dg, input parse_mode_type en);
      alone = 1'b0;
      if (pm == ws) begin
         if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            pm  = dg;
         end else if (is_digit(c)) begin
            acc = 32'(c[3:0]);
            pm  = dg;
         end else if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
            pm = en;
         end
      end else if (pm == dg) begin
         if (is_digit(c)) acc = acc * bsp_pkg::TEN + 32'(c[3:0]);
         else pm = en;
      end
   endtask

   // Advance the shadow parser by one word; yield the bet on the zero byte
   task automatic predict_word(input logic [7:0] c, input logic [bsp_pkg::BET_W-1:0] bet,
                               output bit has, output logic signed [31:0] val);
      logic [31:0] arg;
      logic [31:0] b;
      has = 1'b0;
      val = '0;
      b   = {1'b0, bet};
      if (c == CH_NUL) begin
         has = 1'b1;
         arg = neg ? (32'd0 - acc) : acc;
         case (pm)
            PM_INT, PM_FRAC, PM_SKIP: val = acc;
            PM_PLUS_WS, PM_PLUS_DIG, PM_PLUS_END: begin
               if (alone) arg = 32'(raise_pct);
               val = int'(b * (bsp_pkg::HUNDRED + arg)) / 100;
            end
            PM_MUL_WS, PM_MUL_DIG, PM_MUL_END: begin
               if (alone) arg = 32'(factor);
               val = b * arg;
            end
            default: val = '0;
         endcase
         pm     = PM_START;
         acc    = '0;
         place  = '0;
         neg    = 1'b0;
         alone  = 1'b1;
         nchars = 0;
      end else if (nchars < CHAR_LIMIT) begin
         nchars++;
         case (pm)
            PM_START: begin
               if (is_digit(c)) begin
                  acc = 32'(c[3:0]);
                  pm  = PM_INT;
               end else if (c == CH_PLUS) pm = PM_PLUS_WS;
               else if (c == CH_STAR || c == CH_X) pm = PM_MUL_WS;
               else pm = PM_BAD;
            end
            PM_INT: begin
               if (is_digit(c)) acc = acc * bsp_pkg::TEN + 32'(c[3:0]);
               else if (c == CH_K || c == CH_UK) begin
                  place = 20'(bsp_pkg::THOUSAND);
                  acc   = acc * bsp_pkg::THOUSAND;
                  pm    = PM_FRAC;
               end else if (c == CH_M || c == CH_UM) begin
                  place = 20'(bsp_pkg::MILLION);
                  acc   = acc * bsp_pkg::MILLION;
                  pm    = PM_FRAC;
               end else pm = PM_BAD;
            end
            PM_FRAC: begin
               if (is_digit(c)) begin
                  if (place > 20'd1) begin
                     place = place / 20'd10;
                     acc   = acc + 32'(c[3:0]) * 32'(place);
                  end else pm = PM_SKIP;
               end else pm = PM_BAD;
            end
            PM_PLUS_WS, PM_PLUS_DIG, PM_PLUS_END:
               scan_operand(c, PM_PLUS_WS, PM_PLUS_DIG, PM_PLUS_END);
            PM_MUL_WS, PM_MUL_DIG, PM_MUL_END:
               scan_operand(c, PM_MUL_WS, PM_MUL_DIG, PM_MUL_END);
            default: ;
         endcase
      end
   endtask

   // Send bet_text and its zero byte, one word per handshake
   task automatic send_bet(input logic [bsp_pkg::BET_W-1:0] bet, input bit known,
                           input logic signed [31:0] value);
      int                        gap;
      logic [7:0]                c;
      logic [bsp_pkg::BET_W-1:0] b;
      bit                        has;
      logic signed [31:0]        val;
      for (int i = 0; i <= bet_text.size(); i++) begin
         c   = (i < bet_text.size()) ? bet_text[i] : CH_NUL;
         b   = (c == CH_NUL) ? bet : bsp_pkg::BET_W'($urandom);
         gap = tx_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid       <= 1'b1;
         req_character   <= c;
         req_current_bet <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         predict_word(c, b, has, val);
         if (has) bet_queue.push_back(known ? value : val);
      end
   endtask

   // Drain the parser, then load both default registers
   task automatic write_defaults(input logic [bsp_pkg::CFG_W-1:0] rp,
                                 input logic [bsp_pkg::CFG_W-1:0] fc);
      req_valid <= 1'b0;
      while (bet_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= bsp_pkg::CSR_RAISE_PERCENT;
      csr_wdata <= rp;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      raise_pct = rp;
      csr_index <= bsp_pkg::CSR_FACTOR;
      csr_wdata <= fc;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      factor = fc;
      csr_valid <= 1'b0;
   endtask

   // Take results, check them against the oldest pending bet, stall at random
   initial begin
      int                 hold;
      logic signed [31:0] want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         if (!reset && rsp_valid && !rsp_stall) begin
            if (bet_queue.size() == 0) begin
               $error("bet_value: expected none, actual %0d", rsp_bet_value);
               errors++;
            end else begin
               want = bet_queue.pop_front();
               if (rsp_bet_value !== want) begin
                  $error("bet_value: expected %0d, actual %0d", want, rsp_bet_value);
                  errors++;
               end
            end
            hold = rx_burst ? 0 : $urandom_range(0, 9);
         end
         rsp_stall <= (hold != 0);
      end
   end

   initial begin
      int                        phase_chars;
      int                        kind;
      int                        n;
      logic [bsp_pkg::BET_W-1:0] bet;
      logic [bsp_pkg::CFG_W-1:0] rp;
      logic [bsp_pkg::CFG_W-1:0] fc;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with reset defaults
      for (int r = 0; r < N_DIRECTED; r++) begin
         bet_text.delete();
         for (int j = 0; j < directed_cases[r].head.len(); j++)
            bet_text.push_back(directed_cases[r].head[j]);
         repeat (directed_cases[r].fill_len) bet_text.push_back(directed_cases[r].fill);
         for (int j = 0; j < directed_cases[r].tail.len(); j++)
            bet_text.push_back(directed_cases[r].tail[j]);
         send_bet(directed_cases[r].bet, directed_cases[r].known, directed_cases[r].value);
      end

      // Random strings under several register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin rp = 10'd0;    fc = 10'd0;    end
            1: begin rp = 10'd1000; fc = 10'd1000; end
            2: begin rp = 10'd1000; fc = 10'd0;    end
            3: begin rp = 10'd0;    fc = 10'd1000; end
            default: begin
               rp = 10'($urandom_range(0, 1000));
               fc = 10'($urandom_range(0, 1000));
            end
         endcase
         write_defaults(rp, fc);
         tx_burst    = (ph == 1) || (ph == 5);
         rx_burst    = (ph == 1) || (ph == 6);
         phase_chars = 0;
         while (phase_chars < PHASE_ITEMS) begin
            bet_text.delete();
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
               // decimal number, optional suffix and extra digits
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
               repeat (n) bet_text.push_back(rand_digit());
               if ($urandom_range(0, 1) == 1) begin
                  case ($urandom_range(0, 3))
                     0:       bet_text.push_back(CH_K);
                     1:       bet_text.push_back(CH_UK);
                     2:       bet_text.push_back(CH_M);
                     default: bet_text.push_back(CH_UM);
                  endcase
                  repeat ($urandom_range(0, 8)) bet_text.push_back(rand_digit());
               end
               if ($urandom_range(0, 6) == 0) bet_text.push_back(rand_junk());
            end else if (kind < 80) begin
               // raise or multiply, with or without an operand
               case ($urandom_range(0, 2))
                  0:       bet_text.push_back(CH_PLUS);
                  1:       bet_text.push_back(CH_STAR);
                  default: bet_text.push_back(CH_X);
               endcase
               if ($urandom_range(0, 5) != 0) begin
                  if ($urandom_range(0, 2) == 0)
                     repeat ($urandom_range(1, 3)) bet_text.push_back(rand_space());
                  case ($urandom_range(0, 2))
                     0:       bet_text.push_back(CH_PLUS);
                     1:       bet_text.push_back(CH_MINUS);
                     default: ;
                  endcase
                  n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 11)
                                                  : $urandom_range(0, 4);
                  repeat (n) bet_text.push_back(rand_digit());
                  if ($urandom_range(0, 4) == 0) begin
                     bet_text.push_back(rand_junk());
                     bet_text.push_back(rand_digit());
                  end
               end
            end else if (kind < 99) begin
               // noise
               repeat ($urandom_range(0, 6)) bet_text.push_back(rand_junk());
            end else begin
               // string around the length limit
               n = $urandom_range(CHAR_LIMIT - 10, CHAR_LIMIT + 40);
               case ($urandom_range(0, 2))
                  0: begin
                     bet_text.push_back(CH_PLUS);
                     repeat (n - 3) bet_text.push_back(rand_space());
                  end
                  1: begin
                     bet_text.push_back(CH_X);
                     repeat (n - 3) bet_text.push_back(rand_space());
                  end
                  default: repeat (n - 2) bet_text.push_back(rand_digit());
               endcase
               repeat (2) bet_text.push_back(rand_digit());
            end
            case ($urandom_range(0, 9))
               0:       bet = '0;
               1:       bet = '1;
               2, 3:    bet = bsp_pkg::BET_W'($urandom_range(0, 1000));
               default: bet = bsp_pkg::BET_W'($urandom);
            endcase
            phase_chars += bet_text.size() + 1;
            send_bet(bet, 1'b0, 32'sd0);
         end
      end

      // Let the last results out, then report
      req_valid <= 1'b0;
      while (bet_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
